@@ rtl/core/wwkm_pkg.sv @@
// Shared types, constants and helpers for the whole-word keyword matcher.
`default_nettype none

package wwkm_pkg;

    localparam int CHAR_W     = 8;
    localparam int KEY_W      = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LENGTH = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    // per-cell compare result handed to the match logic
    typedef struct packed {
        logic eq;
        logic letter;
    } cell_stat_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/whole_word_keyword_match.sv @@
// A result is registered and appears in the cycle after the beat carrying the phrase's last character.
// One character per cycle while s_ready is high; the cell chain shifts and compares every accepted beat.
// Input stalls only while a result waits with m_ready low; with m_ready high there are no gaps.
// Reset (aresetn low, synchronous): window, counters and flags cleared, keyword = 0,
// keyword length = 1, no result pending. No clearing pass is needed.
`default_nettype none

module whole_word_keyword_match #(
    parameter int MAX_KEY_LEN = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [wwkm_pkg::CHAR_W-1:0]    s_char_in,
    input  wire logic                           s_phrase_end,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_found,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wwkm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wwkm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wwkm_pkg::*;

    localparam int NCELL = MAX_KEY_LEN + 1;
    localparam int CNT_W = $clog2(MAX_KEY_LEN + 2);
    localparam logic [CNT_W-1:0] SEEN_MAX = CNT_W'(NCELL);
    localparam logic [CNT_W-1:0] LEN_MAX  = CNT_W'(MAX_KEY_LEN);

    logic [KEY_W-1:0]     keyword_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic                 pending_reg, pending_next;
    logic                 found_reg, found_next;
    logic                 m_valid_reg, m_found_reg;

    logic                 accept, last_beat, cell_clear;
    logic [CNT_W-1:0]     len_eff;
    logic [CHAR_W-1:0]    key_bytes [MAX_KEY_LEN];
    logic [CHAR_W-1:0]    key_sel   [NCELL];
    logic [CHAR_W-1:0]    cell_in   [NCELL];
    logic [CHAR_W-1:0]    cell_out  [NCELL];
    cell_stat_t           stat      [NCELL];
    logic                 chars_eq, bound_letter, match_now, confirm;

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign last_beat  = accept && s_phrase_end;
    assign cell_clear = !aresetn || last_beat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keyword_reg <= '0;
            key_len_reg <= KEY_LEN_W'(1);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_KEYWORD_CHARS) begin
                keyword_reg <= cfg_wdata[KEY_W-1:0];
            end else if (cfg_index == CFG_KEYWORD_LENGTH) begin
                key_len_reg <= cfg_wdata[KEY_LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (key_len_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (int'(key_len_reg) > MAX_KEY_LEN) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = CNT_W'(key_len_reg);
        end
    end

    // cell j holds window position j and compares with keyword byte len-1-j
    always_comb begin
        for (int k = 0; k < MAX_KEY_LEN; k++) begin
            key_bytes[k] = keyword_reg[CHAR_W*k +: CHAR_W];
        end
        for (int j = 0; j < NCELL; j++) begin
            key_sel[j] = '0;
            for (int k = 0; k < MAX_KEY_LEN; k++) begin
                if ((CNT_W'(j) < len_eff) &&
                    (len_eff - CNT_W'(1) - CNT_W'(j) == CNT_W'(k))) begin
                    key_sel[j] = key_bytes[k];
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g] = s_char_in;
            end else begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            wwkm_cell u_cell (
                .aclk     (aclk),
                .shift_en (accept),
                .clear    (cell_clear),
                .char_in  (cell_in[g]),
                .key_char (key_sel[g]),
                .char_out (cell_out[g]),
                .stat     (stat[g])
            );
        end
    endgenerate

    always_comb begin
        seen_next = (seen_reg < SEEN_MAX) ? seen_reg + CNT_W'(1) : seen_reg;
        chars_eq     = 1'b1;
        bound_letter = 1'b0;
        for (int j = 0; j < NCELL; j++) begin
            if ((CNT_W'(j) < len_eff) && !stat[j].eq) begin
                chars_eq = 1'b0;
            end
            if (CNT_W'(j) == len_eff) begin
                bound_letter = stat[j].letter;
            end
        end
        match_now = (seen_next >= len_eff) && chars_eq &&
                    !((seen_next > len_eff) && bound_letter);
        confirm      = pending_reg && !stat[0].letter;
        found_next   = found_reg || confirm || (match_now && s_phrase_end);
        pending_next = match_now && !s_phrase_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            pending_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else if (accept) begin
            if (s_phrase_end) begin
                seen_reg    <= '0;
                pending_reg <= 1'b0;
                found_reg   <= 1'b0;
            end else begin
                seen_reg    <= seen_next;
                pending_reg <= pending_next;
                found_reg   <= found_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_beat) begin
            m_found_reg <= found_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        last_beat |=> m_valid)
        else $error("phrase end beat did not produce a result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        last_beat |=> (seen_reg == '0) && !pending_reg && !found_reg)
        else $error("phrase state not cleared after last beat");

    a_found_needs_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg || pending_reg) |-> (seen_reg != '0))
        else $error("match flag set with empty phrase");

endmodule

`default_nettype wire

@@ rtl/core/wwkm_cell.sv @@
// One window cell: holds a character, passes it on, compares the incoming one.
`default_nettype none

module wwkm_cell (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic                       clear,
    input  wire logic [wwkm_pkg::CHAR_W-1:0] char_in,
    input  wire logic [wwkm_pkg::CHAR_W-1:0] key_char,
    output logic      [wwkm_pkg::CHAR_W-1:0] char_out,
    output wwkm_pkg::cell_stat_t            stat
);
    import wwkm_pkg::*;

    logic [CHAR_W-1:0] char_reg;

    always_ff @(posedge aclk) begin
        if (clear) begin
            char_reg <= '0;
        end else if (shift_en) begin
            char_reg <= char_in;
        end
    end

    // flags describe the value this cell holds after the shift
    assign stat.eq     = (char_in == key_char);
    assign stat.letter = is_letter(char_in);
    assign char_out    = char_reg;

endmodule

`default_nettype wire

@@ verif/wwkm_match_checker.sv @@
// Passive checker for the keyword matcher: tracks writes, predicts found per phrase, compares.
`timescale 1ns / 100ps

module wwkm_match_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [wwkm_pkg::CHAR_W-1:0]     s_char_in,
    input  wire logic                            s_phrase_end,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            m_found,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wwkm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wwkm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                   mismatches,
    output int                                   found_owed
);
    import wwkm_pkg::*;

    localparam int KEY_MAX   = 8;
    localparam int WIN_DEPTH = KEY_MAX + 1;

    logic [CHAR_W-1:0]    window [WIN_DEPTH];
    int                   seen;
    logic                 pending;
    logic                 confirmed;
    logic [KEY_W-1:0]     key_chars;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 found_due [$];

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic void clear_phrase();
        foreach (window[i]) window[i] = '0;
        seen      = 0;
        pending   = 1'b0;
        confirmed = 1'b0;
    endfunction

    always @(posedge aclk) begin : watch
        int   eff;
        logic hit;
        logic want;
        if (!aresetn) begin
            key_chars = '0;
            key_len   = KEY_LEN_W'(1);
            clear_phrase();
            found_due.delete();
            found_owed = 0;
            mismatches = 0;
        end else begin
            // result beat first: anything it carries was predicted on an earlier edge
            if (m_valid && m_ready) begin
                if (found_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat found=%0b with nothing due",
                                 $realtime, m_found);
                end else begin
                    want = found_due.pop_front();
                    found_owed--;
                    if (m_found !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: found mismatch, expected %0b got %0b",
                                     $realtime, want, m_found);
                    end
                end
            end

            if (s_valid && s_ready) begin
                eff = (key_len == 0) ? 1 : (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
                // a match that ended last beat needs a non-letter right after it
                if (pending && !is_alpha(s_char_in))
                    confirmed = 1'b1;
                pending = 1'b0;
                for (int i = WIN_DEPTH - 1; i > 0; i--)
                    window[i] = window[i-1];
                window[0] = s_char_in;
                if (seen < WIN_DEPTH)
                    seen++;
                hit = (seen >= eff);
                for (int i = 0; i < eff; i++)
                    if (window[eff-1-i] != key_chars[CHAR_W*i +: CHAR_W])
                        hit = 1'b0;
                if (hit && seen > eff && is_alpha(window[eff]))
                    hit = 1'b0;
                if (hit) begin
                    if (s_phrase_end)
                        confirmed = 1'b1;
                    else
                        pending = 1'b1;
                end
                if (s_phrase_end) begin
                    found_due.push_back(confirmed);
                    found_owed++;
                    clear_phrase();
                end
            end

            // new register values apply from the next beat on
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEYWORD_CHARS:  key_chars = cfg_wdata[KEY_W-1:0];
                    CFG_KEYWORD_LENGTH: key_len   = cfg_wdata[KEY_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ verif/tb_whole_word_keyword_match.sv @@
// Testbench top for the keyword matcher: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_whole_word_keyword_match;
    import wwkm_pkg::*;

    localparam int KEY_MAX      = 8;
    localparam int RAND_ITEMS   = 750;
    localparam int HOLD_CYCLES  = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_char_in;
    logic                  s_phrase_end;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_found;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    found_owed;

    // stimulus-side view of the keyword, used only to build phrases
    logic [KEY_W-1:0] key_stim;
    int               key_len_stim;
    int               gap_pct;
    bit               quiet;
    int               hold_asked;
    int               items_sent;

    whole_word_keyword_match u_top (.*);

    wwkm_match_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : receiver
        int served;
        int stall_pct;
        served    = 0;
        stall_pct = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (served != hold_asked) begin
                served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] rand_letter();
        return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_char_in    <= c;
        s_phrase_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input bit ends);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], ends && (i == txt.len() - 1));
    endtask

    // drop valid, let every due result drain, then allow for the output register
    task automatic quiesce();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (found_owed != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_keyword();
        int                    len;
        logic [KEY_W-1:0]      word;
        logic [CFG_DATA_W-1:0] len_word;
        len      = $urandom_range(1, KEY_MAX);
        word     = {$urandom, $urandom};
        len_word = {$urandom, $urandom};
        for (int i = 0; i < len; i++)
            if ($urandom_range(0, 9) != 0)
                word[CHAR_W*i +: CHAR_W] = rand_letter();
        case ($urandom_range(0, 9))
            0: begin
                len_word[KEY_LEN_W-1:0] = '0;
                len = 1;
            end
            1: begin
                len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(KEY_MAX + 1, 15));
                len = KEY_MAX;
            end
            default: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(len);
        endcase
        key_stim     = word;
        key_len_stim = len;
        cfg_write(CFG_KEYWORD_CHARS, word);
        cfg_write(CFG_KEYWORD_LENGTH, len_word);
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, {$urandom, $urandom});
    endtask

    // phrase built from tokens: keyword (sometimes spoiled), words, separators, noise
    task automatic send_phrase();
        logic [CHAR_W-1:0] text [$];
        logic [CHAR_W-1:0] b;
        int                pos;
        int                cut;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    pos = text.size();
                    for (int i = 0; i < key_len_stim; i++)
                        text.push_back(key_stim[CHAR_W*i +: CHAR_W]);
                    if ($urandom_range(0, 4) == 0) begin
                        pos += $urandom_range(0, key_len_stim - 1);
                        // flip case or replace with any byte
                        text[pos] = $urandom_range(0, 1) ? (text[pos] ^ 8'h20)
                                                         : CHAR_W'($urandom_range(0, 255));
                    end
                end
                4, 5, 6: begin
                    repeat ($urandom_range(1, 4)) text.push_back(rand_letter());
                end
                7, 8: begin
                    repeat ($urandom_range(1, 2)) begin
                        case ($urandom_range(0, 2))
                            0: b = CHAR_W'($urandom_range(0, CHAR_UPPER_A - 1));
                            1: b = CHAR_W'($urandom_range(CHAR_UPPER_Z + 1, CHAR_LOWER_A - 1));
                            default: b = CHAR_W'($urandom_range(CHAR_LOWER_Z + 1, 255));
                        endcase
                        text.push_back(b);
                    end
                end
                default: text.push_back(CHAR_W'($urandom_range(0, 255)));
            endcase
        end
        cut = 0;
        if (text.size() > 1 && $urandom_range(0, 19) == 0)
            cut = $urandom_range(1, text.size() - 1);
        foreach (text[i]) begin
            if (cut != 0 && i == cut) begin
                quiesce();
                load_keyword();
            end
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    initial begin : stimulus
        int  phrases_left;
        bit  pressed;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_char_in    = '0;
        s_phrase_end = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_KEYWORD_CHARS;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        gap_pct      = 20;
        hold_asked   = 0;
        items_sent   = 0;
        key_stim     = '0;
        key_len_stim = 1;
        phrases_left = 0;
        pressed      = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset keyword is a single NUL byte
        send_char(8'h00, 1'b1);

        quiesce();
        cfg_write(CFG_KEYWORD_CHARS, 64'h0000_0000_0074_6163);    // "cat"
        cfg_write(CFG_KEYWORD_LENGTH, 64'd3);
        send_text("cat", 1'b1);
        send_text("cAt", 1'b1);
        send_text("cats", 1'b1);
        send_char(8'hFF, 1'b0);                                   // high byte is a non-letter
        send_text("cat", 1'b1);
        send_text("ca", 1'b1);                                    // too short to match

        // length 0 acts as 1, bytes above it ignored
        quiesce();
        cfg_write(CFG_KEYWORD_CHARS, 64'hFFFF_FFFF_FFFF_FF7A);
        cfg_write(CFG_KEYWORD_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        cfg_write(CFG_SPARE_2, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_SPARE_3, 64'h5555_AAAA_5555_AAAA);
        send_text("z", 1'b1);

        // length 15 saturates to the full eight bytes
        quiesce();
        cfg_write(CFG_KEYWORD_CHARS, 64'h617A_415A_7A61_5A41);    // "AZazZAza"
        cfg_write(CFG_KEYWORD_LENGTH, 64'hF);
        send_text("AZazZAza", 1'b1);

        // keyword swapped mid-phrase while a match waits for its right boundary
        quiesce();
        cfg_write(CFG_KEYWORD_CHARS, 64'h6261);                   // "ab"
        cfg_write(CFG_KEYWORD_LENGTH, 64'd2);
        send_text("ab", 1'b0);
        quiesce();
        cfg_write(CFG_KEYWORD_CHARS, 64'h7A7A);
        send_text(" ", 1'b1);

        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            if (phrases_left == 0) begin
                quiesce();
                load_keyword();
                phrases_left = $urandom_range(6, 14);
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
            end
            // long result stall while beats keep coming: input must back up
            if (!pressed && items_sent >= RAND_ITEMS * 2 / 5) begin
                hold_asked++;
                pressed = 1'b1;
            end
            quiet = (items_sent >= RAND_ITEMS - 100);
            send_phrase();
            phrases_left--;
        end

        quiet = 1'b1;
        s_valid <= 1'b0;
        for (int w = 0; w < 5000 && found_owed != 0; w++)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (mismatches == 0 && found_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ whole_word_keyword_match.f @@
rtl/core/wwkm_pkg.sv
rtl/core/wwkm_cell.sv
rtl/core/whole_word_keyword_match.sv
verif/wwkm_match_checker.sv
verif/tb_whole_word_keyword_match.sv
